// ===== design/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and codes for the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

    typedef enum logic [1:0] {
        OP_ADD        = 2'd0,
        OP_SET_ENABLE = 2'd1,
        OP_TICK       = 2'd2,
        OP_REPORT     = 2'd3
    } op_t;

    localparam logic [1:0] KIND_STATUS   = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_REPORT   = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    // at most this many dispatches per tick
    localparam int         MAX_OUT   = 16;
    localparam int         OUT_CNT_W = 5;

    typedef struct packed {
        op_t         op;
        logic [7:0]  task_id;
        logic [1:0]  prio;
        logic [31:0] interval;
        logic [31:0] limit;
        logic        enable;
        logic [31:0] now;
        logic [31:0] elapsed;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [1:0]  prio;
        logic [31:0] interval;
        logic [31:0] limit;
        logic [31:0] last_run;
        logic [31:0] last_exec;
        logic [31:0] max_exec;
        logic [31:0] runs;
        logic [31:0] overruns;
        logic        enabled;
        logic        oflag;
    } entry_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [7:0]  task_id;
        logic [3:0]  slot;
        logic [31:0] run_count;
        logic [31:0] overrun_count;
        logic [31:0] max_exec;
        logic        overrun;
        logic        last;
    } res_t;

endpackage

// ===== design/ptd_front.sv =====
// ----------------------------------------------------------------------------
// ptd_front
// Request intake: hold requests in a two-deep queue.
// ----------------------------------------------------------------------------
module ptd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ptd_pkg::cmd_t     push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              cmd_valid,
    output ptd_pkg::cmd_t     cmd
);

    ptd_pkg::cmd_t q_reg [2];
    logic [1:0]    cnt_reg, cnt_next;
    logic          rd_reg, rd_next;
    logic          wr_reg, wr_next;
    logic          do_push, do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && cmd_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        wr_next  = wr_reg;
        if (do_push)
        begin
            wr_next = ~wr_reg;
        end
        if (do_pop)
        begin
            rd_next = ~rd_reg;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= push_cmd;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("queue count out of range");
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !pop) |=> full)
        else $error("queue lost a request while full");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("pop did not drop a request");

endmodule

// ===== design/ptd_back.sv =====
// ----------------------------------------------------------------------------
// ptd_back
// Execution: task table in memory, scan sequencer and result register.
// ----------------------------------------------------------------------------
module ptd_back #(
    parameter int MAX_TASKS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  ptd_pkg::cmd_t     cmd,
    output logic              pop,
    output ptd_pkg::res_t     res
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    ptd_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [IW-1:0]                  idx_reg, idx_next;
    logic [1:0]                     pass_reg, pass_next;
    logic                           rvalid_reg, rvalid_next;
    logic [IW-1:0]                  ridx_reg, ridx_next;
    logic [1:0]                     rpass_reg, rpass_next;
    ptd_pkg::entry_t                rdata_reg;
    logic                           found_reg, found_next;
    logic [IW-1:0]                  fslot_reg, fslot_next;
    ptd_pkg::entry_t                ent_reg, ent_next;
    logic [ptd_pkg::OUT_CNT_W-1:0]  nout_reg, nout_next;
    logic                           pend_reg, pend_next;
    logic [7:0]                     pend_id_reg, pend_id_next;
    logic [IW-1:0]                  pend_slot_reg, pend_slot_next;
    ptd_pkg::res_t                  res_reg, res_next;

    ptd_pkg::entry_t                mem [MAX_TASKS];
    logic                           we, re;
    logic [IW-1:0]                  waddr, raddr;
    ptd_pkg::entry_t                wdata;

    logic                           due, hit_tick, hit_search, last_idx;
    logic                           ofl;
    logic [31:0]                    new_max;

    assign res = res_reg;

    assign last_idx   = (idx_reg == IW'(count_reg - CW'(1)));
    assign due        = ((cmd_reg.now - rdata_reg.last_run) >= rdata_reg.interval);
    assign hit_tick   = rvalid_reg && (cmd_reg.op == ptd_pkg::OP_TICK)
                        && (rdata_reg.prio == rpass_reg) && rdata_reg.enabled && due
                        && (nout_reg != ptd_pkg::OUT_CNT_W'(ptd_pkg::MAX_OUT));
    assign hit_search = rvalid_reg && (cmd_reg.op != ptd_pkg::OP_TICK)
                        && (rdata_reg.id == cmd_reg.task_id);
    assign new_max    = (cmd_reg.elapsed > ent_reg.max_exec) ? cmd_reg.elapsed
                                                              : ent_reg.max_exec;
    assign ofl        = (ent_reg.limit != 32'd0) && (cmd_reg.elapsed > ent_reg.limit);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pass_next      = pass_reg;
        rvalid_next    = 1'b0;
        ridx_next      = ridx_reg;
        rpass_next     = rpass_reg;
        found_next     = found_reg;
        fslot_next     = fslot_reg;
        ent_next       = ent_reg;
        nout_next      = nout_reg;
        pend_next      = pend_reg;
        pend_id_next   = pend_id_reg;
        pend_slot_next = pend_slot_reg;
        res_next       = res_reg;
        res_next.valid = 1'b0;
        pop            = 1'b0;
        we             = 1'b0;
        re             = 1'b0;
        waddr          = ridx_reg;
        raddr          = idx_reg;
        wdata          = rdata_reg;

        // evaluate the entry read in the previous cycle
        if (hit_tick)
        begin
            we             = 1'b1;
            wdata.last_run = cmd_reg.now;
            nout_next      = nout_reg + ptd_pkg::OUT_CNT_W'(1);
            if (pend_reg)
            begin
                res_next         = '0;
                res_next.valid   = 1'b1;
                res_next.kind    = ptd_pkg::KIND_DISPATCH;
                res_next.task_id = pend_id_reg;
                res_next.slot    = 4'(pend_slot_reg);
            end
            pend_next      = 1'b1;
            pend_id_next   = rdata_reg.id;
            pend_slot_next = ridx_reg;
        end
        if (hit_search && !found_reg)
        begin
            found_next = 1'b1;
            fslot_next = ridx_reg;
            ent_next   = rdata_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop        = 1'b1;
                    cmd_next   = cmd;
                    idx_next   = '0;
                    pass_next  = 2'd0;
                    found_next = 1'b0;
                    nout_next  = '0;
                    pend_next  = 1'b0;
                    if (count_reg == CW'(0)
                        || (cmd.op == ptd_pkg::OP_ADD && count_reg == CW'(MAX_TASKS)))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit_search)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    re          = 1'b1;
                    rvalid_next = 1'b1;
                    ridx_next   = idx_reg;
                    rpass_next  = pass_reg;
                    if (last_idx)
                    begin
                        idx_next = '0;
                        if (cmd_reg.op == ptd_pkg::OP_TICK && pass_reg != 2'd2)
                        begin
                            pass_next = pass_reg + 2'd1;
                        end
                        else
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next       = ST_IDLE;
                res_next         = '0;
                res_next.valid   = 1'b1;
                res_next.last    = 1'b1;
                res_next.task_id = cmd_reg.task_id;
                case (cmd_reg.op)
                    ptd_pkg::OP_ADD:
                    begin
                        if (count_reg == CW'(MAX_TASKS))
                        begin
                            res_next.status = ptd_pkg::STATUS_FULL;
                        end
                        else if (found_reg)
                        begin
                            res_next.status = ptd_pkg::STATUS_DUPLICATE;
                        end
                        else
                        begin
                            we             = 1'b1;
                            waddr          = IW'(count_reg);
                            wdata          = '0;
                            wdata.id       = cmd_reg.task_id;
                            wdata.prio     = cmd_reg.prio;
                            wdata.interval = cmd_reg.interval;
                            wdata.limit    = cmd_reg.limit;
                            wdata.enabled  = 1'b1;
                            count_next     = count_reg + CW'(1);
                            res_next.slot  = 4'(count_reg);
                        end
                    end
                    ptd_pkg::OP_SET_ENABLE:
                    begin
                        if (found_reg)
                        begin
                            we            = 1'b1;
                            waddr         = fslot_reg;
                            wdata         = ent_reg;
                            wdata.enabled = cmd_reg.enable;
                            res_next.slot = 4'(fslot_reg);
                        end
                        else
                        begin
                            res_next.status = ptd_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    ptd_pkg::OP_TICK:
                    begin
                        res_next.valid   = pend_reg;
                        res_next.kind    = ptd_pkg::KIND_DISPATCH;
                        res_next.task_id = pend_id_reg;
                        res_next.slot    = 4'(pend_slot_reg);
                    end
                    default:
                    begin
                        if (found_reg)
                        begin
                            we                     = 1'b1;
                            waddr                  = fslot_reg;
                            wdata                  = ent_reg;
                            wdata.last_exec        = cmd_reg.elapsed;
                            wdata.max_exec         = new_max;
                            wdata.oflag            = ofl;
                            wdata.runs             = ent_reg.runs + 32'd1;
                            wdata.overruns         = ent_reg.overruns + 32'(ofl);
                            res_next.kind          = ptd_pkg::KIND_REPORT;
                            res_next.slot          = 4'(fslot_reg);
                            res_next.run_count     = wdata.runs;
                            res_next.overrun_count = wdata.overruns;
                            res_next.max_exec      = new_max;
                            res_next.overrun       = ofl;
                        end
                        else
                        begin
                            res_next.status = ptd_pkg::STATUS_NOT_FOUND;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
            res_reg    <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        pass_reg      <= pass_next;
        ridx_reg      <= ridx_next;
        rpass_reg     <= rpass_next;
        found_reg     <= found_next;
        fslot_reg     <= fslot_next;
        ent_reg       <= ent_next;
        nout_reg      <= nout_next;
        pend_reg      <= pend_next;
        pend_id_reg   <= pend_id_next;
        pend_slot_reg <= pend_slot_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TASKS))
        else $error("task count above table size");
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=> (state_reg == ST_IDLE))
        else $error("finish did not return to idle");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE))
        else $error("request taken while busy");
    a_nout_max: assert property (@(posedge clk) disable iff (!rst_n)
        nout_reg <= ptd_pkg::OUT_CNT_W'(ptd_pkg::MAX_OUT) || state_reg == ST_IDLE)
        else $error("too many dispatches");

endmodule

// ===== design/periodic_task_dispatcher.sv =====
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// Periodic task table with add, enable, tick dispatch and run reporting.
// ----------------------------------------------------------------------------
// Add/set-enable/report read the table slot by slot to the matching slot;
// a tick reads the table once per priority 0 to 2, one table read per
// cycle. Throughput: one request per scan; the table memory's single read
// port sets the pace. Two requests may queue while one is carried out.
// Reset clears the task count, state and result register; table contents
// are kept undefined until written by an add. Results cannot be stalled.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher #(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [7:0]  task_id,
    input  logic [1:0]  priority_req,
    input  logic [31:0] interval_ms,
    input  logic [31:0] overrun_limit_us,
    input  logic        enable,
    input  logic [31:0] now_ms,
    input  logic [31:0] elapsed_us,
    output logic        strobe,
    output logic [1:0]  kind,
    output logic [1:0]  status,
    output logic [7:0]  out_task_id,
    output logic [3:0]  slot,
    output logic [31:0] run_count,
    output logic [31:0] overrun_count,
    output logic [31:0] max_exec_us,
    output logic        overrun,
    output logic        last
);

    ptd_pkg::cmd_t in_cmd, q_cmd;
    ptd_pkg::res_t res;
    logic          q_valid, q_pop;

    // pack the request fields
    always_comb
    begin
        in_cmd          = '0;
        in_cmd.op       = ptd_pkg::op_t'(op);
        in_cmd.task_id  = task_id;
        in_cmd.prio     = priority_req;
        in_cmd.interval = interval_ms;
        in_cmd.limit    = overrun_limit_us;
        in_cmd.enable   = enable;
        in_cmd.now      = now_ms;
        in_cmd.elapsed  = elapsed_us;
    end

    // hold requests while the back end scans
    ptd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start),
        .push_cmd  (in_cmd),
        .full      (busy),
        .pop       (q_pop),
        .cmd_valid (q_valid),
        .cmd       (q_cmd)
    );

    // advance through the table and drive the result register
    ptd_back #(
        .MAX_TASKS (MAX_TASKS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .pop       (q_pop),
        .res       (res)
    );

    assign strobe        = res.valid;
    assign kind          = res.kind;
    assign status        = res.status;
    assign out_task_id   = res.task_id;
    assign slot          = res.slot;
    assign run_count     = res.run_count;
    assign overrun_count = res.overrun_count;
    assign max_exec_us   = res.max_exec;
    assign overrun       = res.overrun;
    assign last          = res.last;

endmodule
